### hw/rtl/ssfl_pkg.sv
// Shared types and constants of the slot store allocator.
package ssfl_pkg;

   localparam int unsigned HANDLE_W = 10;
   localparam int unsigned DATA_W   = 64;
   localparam int unsigned DEPTH    = 1 << HANDLE_W;
   localparam int unsigned COUNT_W  = HANDLE_W + 1;

   typedef enum logic [1:0] {
      REQ_STORE   = 2'd0,
      REQ_DISPOSE = 2'd1,
      REQ_READ    = 2'd2,
      REQ_NOP     = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_RANGE = 2'd2,
      STATUS_FREE  = 2'd3
   } status_type;

endpackage

### hw/rtl/ssfl_if.sv
// Request and response channel interfaces of the slot store allocator.
interface ssfl_req_if import ssfl_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [1:0]          req_type;
   logic [HANDLE_W-1:0] handle;
   logic [DATA_W-1:0]   entry_data;

   modport source (output valid, req_type, handle, entry_data, input ready);
   modport sink   (input valid, req_type, handle, entry_data, output ready);
endinterface

interface ssfl_rsp_if import ssfl_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [HANDLE_W-1:0] result_handle;
   logic [DATA_W-1:0]   read_data;
   logic [1:0]          status;

   modport source (output valid, result_handle, read_data, status, input ready);
   modport sink   (input valid, result_handle, read_data, status, output ready);
endinterface

### hw/rtl/ssfl_entry_ram.sv
// Entry memory: one write port, one read port with registered read data.
module ssfl_entry_ram #(
   parameter int unsigned WORD_W = 65,
   parameter int unsigned ADDR_W = 10
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WORD_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WORD_W-1:0] rd_data
);

   logic [WORD_W-1:0] mem [1 << ADDR_W];
   logic [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/slot_store_free_list_allocator.sv
// Slot store with free-list allocator: the top level.
//
// Requests arrive on req_ch (store, dispose or read) and each gives exactly
// one response word on rsp_ch: the handle, the read data and a status.
// A request goes through ST_IDLE, which issues the read of the entry word (the
// free-list head for a store with a non-empty list, the handle otherwise), and
// ST_EXEC, which checks the allocation bit kept in that word, writes back and
// loads the response register; a new request is taken only in ST_IDLE.
// A store reuses the most recently disposed slot, whose link to the next
// free slot sits in the freed entry itself; with no free slot it takes the
// slot at the high-water mark, or reports full at capacity
// (PAGES << PAGE_LOG, at most 1024 entries).
// Reset clears the high-water mark, the free list and the response valid;
// slots beyond the high-water mark are never looked at, so the memory needs
// no clearing pass and the block is ready the cycle after reset.
// The response register holds its word while rsp_ch.ready is low; a new
// request is taken while a response waits only if that response is being
// taken in the same cycle.
module slot_store_free_list_allocator import ssfl_pkg::*; #(
   parameter int unsigned PAGE_LOG   = 8,
   parameter int unsigned PAGES      = 4,
   parameter int unsigned ENTRY_BITS = 64
) (
   input  logic  clock,
   input  logic  reset,
   ssfl_req_if.sink   req_ch,
   ssfl_rsp_if.source rsp_ch
);

   localparam int unsigned RawCap   = PAGES << PAGE_LOG;
   localparam int unsigned Capacity = (RawCap < DEPTH) ? RawCap : DEPTH;
   localparam int unsigned WordW    = ENTRY_BITS + 1;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type               state_ff, state_in;
   req_code_type            req_type_ff, req_type_in;
   logic [HANDLE_W-1:0]     handle_ff, handle_in;
   logic [ENTRY_BITS-1:0]   data_ff, data_in;
   logic [COUNT_W-1:0]      hwm_ff, hwm_in;
   logic [HANDLE_W-1:0]     free_head_ff, free_head_in;
   logic [COUNT_W-1:0]      free_count_ff, free_count_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [HANDLE_W-1:0]     rsp_handle_ff, rsp_handle_in;
   logic [DATA_W-1:0]       rsp_data_ff, rsp_data_in;
   status_type              rsp_status_ff, rsp_status_in;

   logic                    req_ready;
   logic                    wr_en;
   logic [HANDLE_W-1:0]     wr_addr;
   logic [WordW-1:0]        wr_word;
   logic                    rd_en;
   logic [HANDLE_W-1:0]     rd_addr;
   logic [WordW-1:0]        rd_word;
   status_type              chk_status;

   ssfl_entry_ram #(
      .WORD_W (WordW),
      .ADDR_W (HANDLE_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_word),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_word)
   );

   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ch.ready);

   // Top bit of an entry word is its allocation bit.
   always_comb begin
      if (COUNT_W'(handle_ff) >= hwm_ff) begin
         chk_status = STATUS_RANGE;
      end else if (!rd_word[ENTRY_BITS]) begin
         chk_status = STATUS_FREE;
      end else begin
         chk_status = STATUS_OK;
      end
   end

   always_comb begin
      state_in      = state_ff;
      req_type_in   = req_type_ff;
      handle_in     = handle_ff;
      data_in       = data_ff;
      hwm_in        = hwm_ff;
      free_head_in  = free_head_ff;
      free_count_in = free_count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_handle_in = rsp_handle_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      wr_en         = 1'b0;
      wr_addr       = handle_ff;
      wr_word       = '0;
      rd_en         = 1'b0;
      rd_addr       = req_ch.handle;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid && req_ready) begin
               req_type_in = req_code_type'(req_ch.req_type);
               handle_in   = req_ch.handle;
               data_in     = req_ch.entry_data[ENTRY_BITS-1:0];
               rd_en       = 1'b1;
               // Fetch the head entry to pop its link.
               if ((req_code_type'(req_ch.req_type) == REQ_STORE) &&
                   (free_count_ff != '0)) begin
                  rd_addr = free_head_ff;
               end
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in      = ST_IDLE;
            rsp_valid_in  = 1'b1;
            rsp_handle_in = handle_ff;
            rsp_data_in   = '0;
            rsp_status_in = STATUS_OK;
            unique case (req_type_ff)
               REQ_STORE: begin
                  wr_word = {1'b1, data_ff};
                  if (free_count_ff != '0) begin
                     wr_en         = 1'b1;
                     wr_addr       = free_head_ff;
                     rsp_handle_in = free_head_ff;
                     free_head_in  = rd_word[HANDLE_W-1:0];
                     free_count_in = free_count_ff - COUNT_W'(1);
                  end else if (hwm_ff < COUNT_W'(Capacity)) begin
                     wr_en         = 1'b1;
                     wr_addr       = hwm_ff[HANDLE_W-1:0];
                     rsp_handle_in = hwm_ff[HANDLE_W-1:0];
                     hwm_in        = hwm_ff + COUNT_W'(1);
                  end else begin
                     rsp_status_in = STATUS_FULL;
                  end
               end
               REQ_DISPOSE: begin
                  rsp_status_in = chk_status;
                  // Push: the freed entry keeps the old head as its link.
                  wr_word = {1'b0, ENTRY_BITS'(free_head_ff)};
                  if (chk_status == STATUS_OK) begin
                     wr_en         = 1'b1;
                     free_head_in  = handle_ff;
                     free_count_in = free_count_ff + COUNT_W'(1);
                  end
               end
               REQ_READ: begin
                  rsp_status_in = chk_status;
                  if (chk_status == STATUS_OK) begin
                     rsp_data_in = DATA_W'(rd_word[ENTRY_BITS-1:0]);
                  end
               end
               REQ_NOP: begin
                  rsp_status_in = STATUS_OK;
               end
               default: begin
                  rsp_status_in = STATUS_OK;
               end
            endcase
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         hwm_ff        <= '0;
         free_head_ff  <= '0;
         free_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         hwm_ff        <= hwm_in;
         free_head_ff  <= free_head_in;
         free_count_ff <= free_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      req_type_ff   <= req_type_in;
      handle_ff     <= handle_in;
      data_ff       <= data_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_ch.ready         = req_ready;
   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.result_handle = rsp_handle_ff;
   assign rsp_ch.read_data     = rsp_data_ff;
   assign rsp_ch.status        = rsp_status_ff;

endmodule

### tb/slot_store_free_list_allocator_test.sv
// Testbench of the slot store allocator: directed and random requests against a shadow store.
module slot_store_free_list_allocator_test;
   import ssfl_pkg::*;

   localparam int unsigned PAGE_LOG   = 8;
   localparam int unsigned PAGES      = 4;
   localparam int unsigned ENTRY_BITS = 64;
   localparam int unsigned RAW_CAP    = PAGES << PAGE_LOG;
   localparam int unsigned CAPACITY   = (RAW_CAP < DEPTH) ? RAW_CAP : DEPTH;
   localparam logic [DATA_W-1:0] DATA_MASK =
      (ENTRY_BITS >= DATA_W) ? '1 : ((64'd1 << ENTRY_BITS) - 64'd1);
   localparam int unsigned ITEM_GOAL     = 1550;
   localparam int unsigned MISMATCH_SHOW = 10;

   typedef struct packed {
      req_code_type        kind;
      logic [HANDLE_W-1:0] slot;
      logic [DATA_W-1:0]   data;
   } request_type;

   typedef struct packed {
      logic [HANDLE_W-1:0] slot;
      logic [DATA_W-1:0]   data;
      status_type          status;
   } response_type;

   logic clock;
   logic reset;

   ssfl_req_if req_ch ();
   ssfl_rsp_if rsp_ch ();

   slot_store_free_list_allocator #(
      .PAGE_LOG   (PAGE_LOG),
      .PAGES      (PAGES),
      .ENTRY_BITS (ENTRY_BITS)
   ) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // shadow copy of the store
   logic [DATA_W-1:0]   shadow_mem [DEPTH];
   logic                shadow_alloc [DEPTH];
   logic [COUNT_W-1:0]  shadow_mark;
   logic [COUNT_W-1:0]  shadow_free_count;
   logic [HANDLE_W-1:0] shadow_head;

   request_type  pending_requests[$];
   response_type expected_responses[$];
   request_type  driven_request;
   response_type expected_word;
   int unsigned  issued_count;
   int unsigned  mismatch_count;

   initial begin : clock_gen
      clock = 1'b0;
      reset = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.req_type   = REQ_NOP;
      req_ch.handle     = '0;
      req_ch.entry_data = '0;
      rsp_ch.ready      = 1'b0;
      for (int k = 0; k < DEPTH; k++) begin
         shadow_mem[k]   = '0;
         shadow_alloc[k] = 1'b0;
      end
      shadow_mark       = '0;
      shadow_free_count = '0;
      shadow_head       = '0;
      issued_count      = 0;
      mismatch_count    = 0;
      forever #5 clock = ~clock;
   end

   initial begin : watchdog
      #2000000;
      $display("RESULT: ERROR");
      $finish;
   end

   function automatic status_type check_slot(logic [HANDLE_W-1:0] slot);
      if (slot >= shadow_mark)
         return STATUS_RANGE;
      if (!shadow_alloc[slot])
         return STATUS_FREE;
      return STATUS_OK;
   endfunction

   function automatic response_type predict_response(request_type r);
      response_type        result;
      logic [HANDLE_W-1:0] slot;
      result.slot   = r.slot;
      result.data   = '0;
      result.status = STATUS_OK;
      case (r.kind)
         REQ_STORE: begin
            if (shadow_free_count != 0) begin
               // pop the free list: the link sits in the freed entry
               slot = shadow_head;
               shadow_head = shadow_mem[slot][HANDLE_W-1:0];
               shadow_free_count = shadow_free_count - 1'b1;
               shadow_alloc[slot] = 1'b1;
               shadow_mem[slot] = r.data & DATA_MASK;
               result.slot = slot;
            end else if (shadow_mark < CAPACITY) begin
               slot = shadow_mark[HANDLE_W-1:0];
               shadow_alloc[slot] = 1'b1;
               shadow_mem[slot] = r.data & DATA_MASK;
               shadow_mark = shadow_mark + 1'b1;
               result.slot = slot;
            end else begin
               result.status = STATUS_FULL;
            end
         end
         REQ_DISPOSE: begin
            result.status = check_slot(r.slot);
            if (result.status == STATUS_OK) begin
               shadow_alloc[r.slot] = 1'b0;
               shadow_mem[r.slot] = DATA_W'(shadow_head);
               shadow_head = r.slot;
               shadow_free_count = shadow_free_count + 1'b1;
            end
         end
         REQ_READ: begin
            result.status = check_slot(r.slot);
            if (result.status == STATUS_OK)
               result.data = shadow_mem[r.slot];
         end
         default: ;
      endcase
      return result;
   endfunction

   // random stalls, except for one quiet stretch of the run
   function automatic logic take_break();
      if ($time >= 15000 && $time < 30000)
         return 1'b0;
      return $urandom_range(99) < 15;
   endfunction

   function automatic logic [HANDLE_W-1:0] pick_slot();
      int unsigned roll;
      int unsigned start;
      int unsigned idx;
      roll = $urandom_range(99);
      if (roll < 10 || shadow_mark == 0)
         return HANDLE_W'($urandom_range(DEPTH - 1));
      start = $urandom_range(shadow_mark - 1);
      if (roll < 20)
         return HANDLE_W'(start);
      // prefer a live entry: scan forward from a random point
      for (int k = 0; k < shadow_mark; k++) begin
         idx = (start + k) % shadow_mark;
         if (shadow_alloc[idx])
            return HANDLE_W'(idx);
      end
      return HANDLE_W'(start);
   endfunction

   task automatic queue_request(req_code_type kind, logic [HANDLE_W-1:0] slot,
                                logic [DATA_W-1:0] data);
      request_type r;
      while (pending_requests.size() > 2)
         @(negedge clock);
      r.kind = kind;
      r.slot = slot;
      r.data = data;
      pending_requests.push_back(r);
      issued_count++;
   endtask

   task automatic queue_random(int unsigned store_pct, int unsigned dispose_pct,
                               int unsigned read_pct);
      int unsigned         roll;
      req_code_type        kind;
      logic [HANDLE_W-1:0] slot;
      roll = $urandom_range(99);
      if (roll < store_pct)
         kind = REQ_STORE;
      else if (roll < store_pct + dispose_pct)
         kind = REQ_DISPOSE;
      else if (roll < store_pct + dispose_pct + read_pct)
         kind = REQ_READ;
      else
         kind = REQ_NOP;
      slot = (kind == REQ_STORE) ? HANDLE_W'($urandom_range(DEPTH - 1)) : pick_slot();
      queue_request(kind, slot, {$urandom, $urandom});
   endtask

   // driver: advance to the next word once the held one is taken
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready)
            expected_responses.push_back(predict_response(driven_request));
         if (!req_ch.valid || req_ch.ready) begin
            if (pending_requests.size() != 0 && !take_break()) begin
               driven_request = pending_requests.pop_front();
               req_ch.valid      <= 1'b1;
               req_ch.req_type   <= driven_request.kind;
               req_ch.handle     <= driven_request.slot;
               req_ch.entry_data <= driven_request.data;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_responses.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MISMATCH_SHOW)
                  $display("unexpected response word: handle %0d data %h status %0d",
                           rsp_ch.result_handle, rsp_ch.read_data, rsp_ch.status);
            end else begin
               expected_word = expected_responses.pop_front();
               if (rsp_ch.result_handle !== expected_word.slot ||
                   rsp_ch.read_data !== expected_word.data ||
                   rsp_ch.status !== expected_word.status) begin
                  mismatch_count++;
                  if (mismatch_count <= MISMATCH_SHOW)
                     $display({"mismatch: expected handle %0d data %h status %0d, ",
                               "got handle %0d data %h status %0d"},
                              expected_word.slot, expected_word.data, expected_word.status,
                              rsp_ch.result_handle, rsp_ch.read_data, rsp_ch.status);
               end
            end
         end
         rsp_ch.ready <= !take_break();
      end
   end

   initial begin : stimulus
      int unsigned fill_items;
      int unsigned drain_items;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty store, unused code, extremes of the data
      queue_request(REQ_READ,    10'd0,    64'd0);
      queue_request(REQ_DISPOSE, 10'd1023, 64'd0);
      queue_request(REQ_NOP,     10'd1023, '1);
      queue_request(REQ_STORE,   10'd1023, 64'd0);
      queue_request(REQ_STORE,   10'd0,    '1);
      queue_request(REQ_STORE,   10'd0,    64'h5555_5555_5555_5555);
      queue_request(REQ_STORE,   10'd0,    64'hAAAA_AAAA_AAAA_AAAA);
      queue_request(REQ_READ,    10'd1,    64'd0);
      queue_request(REQ_READ,    10'd3,    64'd0);
      queue_request(REQ_READ,    10'd1023, 64'd0);
      // free slots, double dispose, LIFO reuse
      queue_request(REQ_DISPOSE, 10'd1,    64'd0);
      queue_request(REQ_READ,    10'd1,    64'd0);
      queue_request(REQ_DISPOSE, 10'd1,    64'd0);
      queue_request(REQ_DISPOSE, 10'd3,    64'd0);
      queue_request(REQ_STORE,   10'd0,    64'h0123_4567_89AB_CDEF);
      queue_request(REQ_STORE,   10'd0,    64'hFEDC_BA98_7654_3210);
      queue_request(REQ_STORE,   10'd0,    64'h8000_0000_0000_0001);
      queue_request(REQ_READ,    10'd0,    64'd0);
      queue_request(REQ_DISPOSE, 10'd4,    64'd0);
      queue_request(REQ_DISPOSE, 10'd0,    64'd0);
      queue_request(REQ_NOP,     10'd0,    64'd0);
      queue_request(REQ_READ,    10'd4,    64'd0);

      // churn around a small population
      repeat (400) queue_random(35, 30, 30);
      // grow until full, then hit the full case a few times
      fill_items = 0;
      while (fill_items < 1300 && !(shadow_mark == CAPACITY && shadow_free_count == 0)) begin
         queue_random(92, 4, 4);
         fill_items++;
      end
      repeat (40) queue_random(80, 5, 15);
      // drain through the free list
      drain_items = (issued_count + 100 < ITEM_GOAL) ? ITEM_GOAL - issued_count : 100;
      repeat (drain_items) queue_random(20, 50, 25);

      while (pending_requests.size() != 0 || req_ch.valid || expected_responses.size() != 0)
         @(negedge clock);
      repeat (10) @(negedge clock);
      if (mismatch_count == 0 && expected_responses.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

### filelist.f
hw/rtl/ssfl_pkg.sv
hw/rtl/ssfl_if.sv
hw/rtl/ssfl_entry_ram.sv
hw/rtl/slot_store_free_list_allocator.sv
tb/slot_store_free_list_allocator_test.sv
